/* src/hptc_pkg.sv */
// shared types and constants of the hashed page table cache
package hptc_pkg;

   localparam int VPAGE_BITS     = 32;
   localparam int PHYS_BITS      = 32;
   localparam int PAGES_PER_LINE = 8;
   localparam int SLOT_W         = $clog2(PAGES_PER_LINE);
   localparam int TAG_W          = VPAGE_BITS - SLOT_W;
   localparam int USED_W         = $clog2(PAGES_PER_LINE + 1);
   localparam int REF_BITS       = 8;
   localparam int CFG_W          = 11;

   localparam logic [2:0] OP_CREATE   = 3'd0;
   localparam logic [2:0] OP_COMPLETE = 3'd1;
   localparam logic [2:0] OP_PIN      = 3'd2;
   localparam logic [2:0] OP_UNPIN    = 3'd3;
   localparam logic [2:0] OP_DELETE   = 3'd4;
   localparam logic [2:0] OP_EVICT    = 3'd5;

   localparam logic [2:0] STAT_OK       = 3'd0;
   localparam logic [2:0] STAT_ABSENT   = 3'd1;
   localparam logic [2:0] STAT_SLOT     = 3'd2;
   localparam logic [2:0] STAT_POOL     = 3'd3;
   localparam logic [2:0] STAT_SATURATE = 3'd4;
   localparam logic [2:0] STAT_NOVICT   = 3'd5;

   localparam int FLAG_EXIST = 0;
   localparam int FLAG_BUSY  = 1;
   localparam int FLAG_DIRTY = 2;
   localparam int FLAG_ACC   = 3;

   localparam logic [REF_BITS-1:0] REF_MAX = '1;

   typedef struct packed {
      logic [3:0]           flags;
      logic [REF_BITS-1:0]  ref_cnt;
      logic [PHYS_BITS-1:0] phys;
   } slot_type;

   typedef slot_type [PAGES_PER_LINE-1:0] slot_row_type;

endpackage

/* src/hptc_ram.sv */
// generic single-write, single-read ram with registered read data
module hptc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

/* src/hptc_mod.sv */
// bit-serial remainder unit, one dividend bit per cycle
module hptc_mod #(
   parameter int DW = 29,
   parameter int RW = 11
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] dividend,
   input  logic [RW-1:0] divisor,
   output logic          done,
   output logic [RW-1:0] remainder
);
   localparam int CW = (DW > 1) ? $clog2(DW) : 1;

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [DW-1:0] dvd_ff, dvd_in;
   logic [RW-1:0] dvs_ff, dvs_in;
   logic [RW-1:0] rem_ff, rem_in;
   logic [RW:0]   trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      trial   = {rem_ff, dvd_ff[DW-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(DW - 1);
         dvd_in  = dividend;
         dvs_in  = divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = RW'(trial - {1'b0, dvs_ff});
         end else begin
            rem_in = trial[RW-1:0];
         end
         dvd_in = dvd_ff << 1;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;
endmodule

/* src/hashed_page_table_cache.sv */
// hashed page table cache top level: sequencer around the line, slot and free-line rams
// a request: accept, bucket remainder of the tag, a read of each chain line,
//   the writes and a result step; evict runs the same remainder step on the bucket
//   after the clock hand, then walks bucket chains over up to bucket_count-1 buckets
// throughput: one request at a time; the chain walk through the line ram sets the pace
// reset: a clearing pass over all BUCKETS+POOL_LINES lines empties every line and slot row
//   and refills the free-line stack; no request is taken before it ends
module hashed_page_table_cache #(
   parameter int BUCKETS    = 1024,
   parameter int POOL_LINES = 512
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [2:0]                    req_operation,
   input  logic [hptc_pkg::VPAGE_BITS-1:0] req_virtual_page,
   input  logic [hptc_pkg::PHYS_BITS-1:0]  req_physical_page,
   input  logic                          req_write_flag,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [2:0]                    rsp_status,
   output logic [hptc_pkg::PHYS_BITS-1:0]  rsp_physical_page_out,
   output logic [hptc_pkg::VPAGE_BITS-1:0] rsp_victim_page,
   output logic                          rsp_victim_dirty,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [hptc_pkg::CFG_W-1:0]    csr_bucket_count
);
   import hptc_pkg::*;

   localparam int NLINES = BUCKETS + POOL_LINES;
   localparam int LINE_W = $clog2(NLINES);
   localparam int BKT_W  = $clog2(BUCKETS);
   localparam int EB_W   = $clog2(BUCKETS + 1);
   localparam int POOL_W = (POOL_LINES > 1) ? $clog2(POOL_LINES) : 1;
   localparam int FCNT_W = $clog2(POOL_LINES + 1);

   // one line: tag, slot fill and the link to the next pool line of the chain
   typedef struct packed {
      logic              tag_valid;
      logic [TAG_W-1:0]  tag;
      logic [USED_W-1:0] used;
      logic              next_valid;
      logic [POOL_W-1:0] next;
   } line_type;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_DIV, ST_READ, ST_CHECK, ST_POP, ST_POPW,
      ST_EXEC, ST_UNLINK, ST_BUCKET, ST_DONE
   } state_type;

   state_type          state_ff, state_in;
   logic [LINE_W-1:0]  clr_idx_ff, clr_idx_in;
   logic [CFG_W-1:0]   bucket_count_ff, bucket_count_in;
   logic [2:0]         op_ff, op_in;
   logic [TAG_W-1:0]   tag_ff, tag_in;
   logic [SLOT_W-1:0]  slot_ff, slot_in;
   logic [PHYS_BITS-1:0] pp_ff, pp_in;
   logic               wr_ff, wr_in;
   logic [EB_W-1:0]    eb_ff, eb_in;
   logic [BKT_W-1:0]   home_ff, home_in;
   logic [LINE_W-1:0]  cur_ff, cur_in;
   logic [LINE_W-1:0]  prev_ff, prev_in;
   line_type           prev_ent_ff, prev_ent_in;
   line_type           cur_ent_ff, cur_ent_in;
   line_type           home_ent_ff, home_ent_in;
   slot_row_type       row_ff, row_in;
   logic               first_ff, first_in;
   logic [FCNT_W-1:0]  free_cnt_ff, free_cnt_in;
   logic [BKT_W-1:0]   hand_ff, hand_in;
   logic [BKT_W-1:0]   h_ff, h_in;
   logic [EB_W-1:0]    cnt_ff, cnt_in;
   logic [2:0]         status_ff, status_in;
   logic [PHYS_BITS-1:0]  pout_ff, pout_in;
   logic [VPAGE_BITS-1:0] vout_ff, vout_in;
   logic               dout_ff, dout_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [2:0]         rsp_status_ff, rsp_status_in;
   logic [PHYS_BITS-1:0]  rsp_pout_ff, rsp_pout_in;
   logic [VPAGE_BITS-1:0] rsp_vout_ff, rsp_vout_in;
   logic               rsp_dout_ff, rsp_dout_in;

   // ram ports
   logic               line_we, slot_we, stack_we;
   logic [LINE_W-1:0]  line_waddr, slot_waddr;
   logic [POOL_W-1:0]  stack_waddr, stack_raddr, stack_wdata, stack_rd;
   line_type           line_wdata, line_rd;
   slot_row_type       slot_wdata, slot_rd;

   // bucket remainder unit
   logic               mod_start, mod_done;
   logic [EB_W-1:0]    mod_rem;
   logic [TAG_W-1:0]   mod_dvd;
   logic [31:0]        bc32, eb_now32;

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign stack_raddr = POOL_W'(free_cnt_ff - 1'b1);

   // evict reduces the bucket after the clock hand, the others reduce the tag
   assign mod_dvd = (req_operation == OP_EVICT) ? (TAG_W'(hand_ff) + TAG_W'(1))
                                                : req_virtual_page[VPAGE_BITS-1:SLOT_W];

   // effective bucket count: zero acts as one, large values clamp to BUCKETS
   always_comb begin
      bc32 = 32'(bucket_count_ff);
      if (bc32 == 32'd0) begin
         eb_now32 = 32'd1;
      end else if (bc32 > 32'(BUCKETS)) begin
         eb_now32 = 32'(BUCKETS);
      end else begin
         eb_now32 = bc32;
      end
   end

   hptc_mod #(.DW(TAG_W), .RW(EB_W)) u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (mod_dvd),
      .divisor   (EB_W'(eb_now32)),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   hptc_ram #(.WIDTH($bits(line_type)), .DEPTH(NLINES)) u_line_ram (
      .clock   (clock),
      .wr_en   (line_we),
      .wr_addr (line_waddr),
      .wr_data (line_wdata),
      .rd_addr (cur_ff),
      .rd_data (line_rd)
   );

   hptc_ram #(.WIDTH($bits(slot_row_type)), .DEPTH(NLINES)) u_slot_ram (
      .clock   (clock),
      .wr_en   (slot_we),
      .wr_addr (slot_waddr),
      .wr_data (slot_wdata),
      .rd_addr (cur_ff),
      .rd_data (slot_rd)
   );

   hptc_ram #(.WIDTH(POOL_W), .DEPTH(POOL_LINES)) u_stack_ram (
      .clock   (clock),
      .wr_en   (stack_we),
      .wr_addr (stack_waddr),
      .wr_data (stack_wdata),
      .rd_addr (stack_raddr),
      .rd_data (stack_rd)
   );

   always_comb begin
      slot_type          e;
      slot_row_type      row_new;
      line_type          ent_new;
      logic [USED_W-1:0] used_new;
      logic [PAGES_PER_LINE-1:0] cand, acc;
      logic              pick_found;
      logic [SLOT_W-1:0] pick_idx;
      logic              hit;
      logic [31:0]       hn32;

      state_in        = state_ff;
      clr_idx_in      = clr_idx_ff;
      bucket_count_in = bucket_count_ff;
      op_in           = op_ff;
      tag_in          = tag_ff;
      slot_in         = slot_ff;
      pp_in           = pp_ff;
      wr_in           = wr_ff;
      eb_in           = eb_ff;
      home_in         = home_ff;
      cur_in          = cur_ff;
      prev_in         = prev_ff;
      prev_ent_in     = prev_ent_ff;
      cur_ent_in      = cur_ent_ff;
      home_ent_in     = home_ent_ff;
      row_in          = row_ff;
      first_in        = first_ff;
      free_cnt_in     = free_cnt_ff;
      hand_in         = hand_ff;
      h_in            = h_ff;
      cnt_in          = cnt_ff;
      status_in       = status_ff;
      pout_in         = pout_ff;
      vout_in         = vout_ff;
      dout_in         = dout_ff;
      rsp_valid_in    = rsp_valid_ff & ~rsp_ready;
      rsp_status_in   = rsp_status_ff;
      rsp_pout_in     = rsp_pout_ff;
      rsp_vout_in     = rsp_vout_ff;
      rsp_dout_in     = rsp_dout_ff;
      line_we         = 1'b0;
      slot_we         = 1'b0;
      stack_we        = 1'b0;
      line_waddr      = cur_ff;
      slot_waddr      = cur_ff;
      stack_waddr     = POOL_W'(free_cnt_ff);
      line_wdata      = '0;
      slot_wdata      = '0;
      stack_wdata     = '0;
      mod_start       = 1'b0;
      e               = row_ff[slot_ff];
      row_new         = row_ff;
      ent_new         = cur_ent_ff;
      used_new        = cur_ent_ff.used;
      hit             = line_rd.tag_valid && (line_rd.tag == tag_ff);
      hn32            = 32'(h_ff) + 32'd1;
      pick_found      = 1'b0;
      pick_idx        = '0;

      // second-chance candidates of the line just read
      for (int i = 0; i < PAGES_PER_LINE; i++) begin
         cand[i] = slot_rd[i].flags[FLAG_EXIST] && !slot_rd[i].flags[FLAG_BUSY]
                   && (slot_rd[i].ref_cnt == '0);
         acc[i]  = slot_rd[i].flags[FLAG_ACC];
      end
      for (int i = PAGES_PER_LINE - 1; i >= 0; i--) begin
         if (cand[i] && !acc[i]) begin
            pick_found = 1'b1;
            pick_idx   = SLOT_W'(i);
         end
      end

      if (csr_valid) begin
         bucket_count_in = csr_bucket_count;
      end

      unique case (state_ff)
         // reset pass: empty every line and slot row, refill the free stack
         ST_CLEAR: begin
            line_we    = 1'b1;
            line_waddr = clr_idx_ff;
            slot_we    = 1'b1;
            slot_waddr = clr_idx_ff;
            if (32'(clr_idx_ff) < 32'(POOL_LINES)) begin
               stack_we    = 1'b1;
               stack_waddr = POOL_W'(clr_idx_ff);
               stack_wdata = POOL_W'(clr_idx_ff);
            end
            if (32'(clr_idx_ff) == 32'(NLINES - 1)) begin
               state_in = ST_IDLE;
            end else begin
               clr_idx_in = clr_idx_ff + 1'b1;
            end
         end

         ST_IDLE: begin
            if (req_valid) begin
               op_in     = req_operation;
               tag_in    = req_virtual_page[VPAGE_BITS-1:SLOT_W];
               slot_in   = req_virtual_page[SLOT_W-1:0];
               pp_in     = req_physical_page;
               wr_in     = req_write_flag;
               eb_in     = EB_W'(eb_now32);
               first_in  = 1'b1;
               status_in = STAT_OK;
               pout_in   = '0;
               vout_in   = '0;
               dout_in   = 1'b0;
               cnt_in    = '0;
               if (req_operation <= OP_EVICT) begin
                  mod_start = 1'b1;
                  state_in  = ST_DIV;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end

         // wait for tag (or hand + 1) modulo bucket count
         ST_DIV: begin
            if (mod_done) begin
               if (op_ff == OP_EVICT) begin
                  // park one bucket back so the first hand step lands on the remainder
                  if (mod_rem == '0) begin
                     h_in = BKT_W'(eb_ff - 1'b1);
                  end else begin
                     h_in = BKT_W'(mod_rem - 1'b1);
                  end
                  state_in = ST_BUCKET;
               end else begin
                  home_in  = BKT_W'(mod_rem);
                  cur_in   = LINE_W'(mod_rem);
                  state_in = ST_READ;
               end
            end
         end

         ST_READ: begin
            state_in = ST_CHECK;
         end

         // line and slot row of cur are on the read ports
         ST_CHECK: begin
            first_in = 1'b0;
            if (op_ff == OP_EVICT) begin
               if (pick_found) begin
                  cur_ent_in = line_rd;
                  for (int i = 0; i < PAGES_PER_LINE; i++) begin
                     row_in[i] = slot_rd[i];
                     if (cand[i] && acc[i] && (i < 32'(pick_idx))) begin
                        row_in[i].flags[FLAG_ACC] = 1'b0;
                     end
                  end
                  slot_in  = pick_idx;
                  vout_in  = VPAGE_BITS'({line_rd.tag, pick_idx});
                  dout_in  = slot_rd[pick_idx].flags[FLAG_DIRTY];
                  state_in = ST_EXEC;
               end else begin
                  // no victim here: accessed candidates lose their second chance
                  slot_we    = 1'b1;
                  slot_waddr = cur_ff;
                  for (int i = 0; i < PAGES_PER_LINE; i++) begin
                     slot_wdata[i] = slot_rd[i];
                     if (cand[i]) begin
                        slot_wdata[i].flags[FLAG_ACC] = 1'b0;
                     end
                  end
                  if (line_rd.next_valid) begin
                     prev_in     = cur_ff;
                     prev_ent_in = line_rd;
                     cur_in      = LINE_W'(BUCKETS) + LINE_W'(line_rd.next);
                     state_in    = ST_READ;
                  end else begin
                     cnt_in   = cnt_ff + 1'b1;
                     state_in = ST_BUCKET;
                  end
               end
            end else begin
               if (first_ff) begin
                  home_ent_in = line_rd;
               end
               if (hit) begin
                  cur_ent_in = line_rd;
                  row_in     = slot_rd;
                  state_in   = ST_EXEC;
               end else if (line_rd.next_valid) begin
                  prev_in     = cur_ff;
                  prev_ent_in = line_rd;
                  cur_in      = LINE_W'(BUCKETS) + LINE_W'(line_rd.next);
                  state_in    = ST_READ;
               end else if (op_ff != OP_CREATE) begin
                  status_in = STAT_ABSENT;
                  state_in  = ST_DONE;
               end else if (!(first_ff ? line_rd.tag_valid : home_ent_ff.tag_valid)) begin
                  // empty home line is reused and keeps its chain
                  cur_in               = LINE_W'(home_ff);
                  cur_ent_in           = first_ff ? line_rd : home_ent_ff;
                  cur_ent_in.tag_valid = 1'b1;
                  cur_ent_in.tag       = tag_ff;
                  cur_ent_in.used      = '0;
                  row_in               = '0;
                  state_in             = ST_EXEC;
               end else if (free_cnt_ff == '0) begin
                  status_in = STAT_POOL;
                  state_in  = ST_DONE;
               end else begin
                  // chain end becomes the predecessor of a popped pool line
                  prev_in     = cur_ff;
                  prev_ent_in = line_rd;
                  state_in    = ST_POP;
               end
            end
         end

         ST_POP: begin
            state_in = ST_POPW;
         end

         ST_POPW: begin
            free_cnt_in           = free_cnt_ff - 1'b1;
            line_we               = 1'b1;
            line_waddr            = prev_ff;
            line_wdata            = prev_ent_ff;
            line_wdata.next_valid = 1'b1;
            line_wdata.next       = stack_rd;
            cur_in                = LINE_W'(BUCKETS) + LINE_W'(stack_rd);
            cur_ent_in            = '0;
            cur_ent_in.tag_valid  = 1'b1;
            cur_ent_in.tag        = tag_ff;
            row_in                = '0;
            state_in              = ST_EXEC;
         end

         // modify the addressed slot and write the row back, and the line when its fill changes
         ST_EXEC: begin
            state_in = ST_DONE;
            case (op_ff) inside
               OP_CREATE: begin
                  if (e.flags != '0 || e.ref_cnt != '0) begin
                     status_in = STAT_SLOT;
                  end else begin
                     row_new[slot_ff].flags   = '0;
                     row_new[slot_ff].flags[FLAG_EXIST] = 1'b1;
                     row_new[slot_ff].flags[FLAG_BUSY]  = 1'b1;
                     row_new[slot_ff].flags[FLAG_DIRTY] = wr_ff;
                     row_new[slot_ff].ref_cnt = '0;
                     row_new[slot_ff].phys    = pp_ff;
                     ent_new.used = cur_ent_ff.used + 1'b1;
                     line_we      = 1'b1;
                     line_wdata   = ent_new;
                     slot_we      = 1'b1;
                     slot_wdata   = row_new;
                  end
               end
               OP_COMPLETE: begin
                  if (!e.flags[FLAG_EXIST] || !e.flags[FLAG_BUSY]) begin
                     status_in = STAT_SLOT;
                  end else begin
                     row_new[slot_ff].flags[FLAG_BUSY] = 1'b0;
                     row_new[slot_ff].phys = pp_ff;
                     slot_we    = 1'b1;
                     slot_wdata = row_new;
                  end
               end
               OP_PIN: begin
                  if (e.ref_cnt == REF_MAX) begin
                     status_in = STAT_SATURATE;
                  end else begin
                     row_new[slot_ff].ref_cnt = e.ref_cnt + 1'b1;
                     pout_in    = e.phys;
                     slot_we    = 1'b1;
                     slot_wdata = row_new;
                  end
               end
               OP_UNPIN: begin
                  if (e.ref_cnt == '0) begin
                     status_in = STAT_SLOT;
                  end else begin
                     row_new[slot_ff].ref_cnt = e.ref_cnt - 1'b1;
                     if (e.ref_cnt == REF_BITS'(1)) begin
                        row_new[slot_ff].flags[FLAG_ACC] = 1'b1;
                     end
                     if (wr_ff) begin
                        row_new[slot_ff].flags[FLAG_DIRTY] = 1'b1;
                     end
                     slot_we    = 1'b1;
                     slot_wdata = row_new;
                  end
               end
               OP_DELETE, OP_EVICT: begin
                  if (!e.flags[FLAG_EXIST] || e.flags[FLAG_BUSY] || e.flags[FLAG_ACC]
                      || e.ref_cnt != '0) begin
                     status_in = STAT_SLOT;
                  end else begin
                     if (op_ff == OP_EVICT) begin
                        hand_in = h_ff;
                     end
                     row_new[slot_ff].flags[FLAG_EXIST] = 1'b0;
                     row_new[slot_ff].flags[FLAG_DIRTY] = 1'b0;
                     row_new[slot_ff].phys = '0;
                     used_new = (cur_ent_ff.used == '0) ? '0 : cur_ent_ff.used - 1'b1;
                     ent_new.used = used_new;
                     if (used_new == '0) begin
                        // last slot gone: line is freed
                        ent_new.tag_valid = 1'b0;
                        row_new           = '0;
                        if (cur_ff != LINE_W'(home_ff)) begin
                           ent_new.next_valid = 1'b0;
                           ent_new.next       = '0;
                           state_in           = ST_UNLINK;
                        end
                     end
                     line_we    = 1'b1;
                     line_wdata = ent_new;
                     slot_we    = 1'b1;
                     slot_wdata = row_new;
                  end
               end
               default: begin
                  status_in = STAT_OK;
               end
            endcase
         end

         // predecessor skips the freed pool line, which goes back on the stack
         ST_UNLINK: begin
            line_we               = 1'b1;
            line_waddr            = prev_ff;
            line_wdata            = prev_ent_ff;
            line_wdata.next_valid = cur_ent_ff.next_valid;
            line_wdata.next       = cur_ent_ff.next;
            if (32'(free_cnt_ff) < 32'(POOL_LINES)) begin
               stack_we    = 1'b1;
               stack_waddr = POOL_W'(free_cnt_ff);
               stack_wdata = POOL_W'(cur_ff - LINE_W'(BUCKETS));
               free_cnt_in = free_cnt_ff + 1'b1;
            end
            state_in = ST_DONE;
         end

         // clock hand step to the next bucket, or no victim once the bucket count is used up
         ST_BUCKET: begin
            if (32'(cnt_ff) + 32'd1 < 32'(eb_ff)) begin
               if (hn32 == 32'(eb_ff)) begin
                  hn32 = 32'd0;
               end
               h_in     = BKT_W'(hn32);
               home_in  = BKT_W'(hn32);
               cur_in   = LINE_W'(hn32);
               state_in = ST_READ;
            end else begin
               status_in = STAT_NOVICT;
               vout_in   = '0;
               dout_in   = 1'b0;
               state_in  = ST_DONE;
            end
         end

         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_pout_in   = (status_ff == STAT_OK) ? pout_ff : '0;
               rsp_vout_in   = (status_ff == STAT_OK) ? vout_ff : '0;
               rsp_dout_in   = (status_ff == STAT_OK) ? dout_ff : 1'b0;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_CLEAR;
         clr_idx_ff      <= '0;
         bucket_count_ff <= CFG_W'(1024);
         free_cnt_ff     <= FCNT_W'(POOL_LINES);
         hand_ff         <= '0;
         rsp_valid_ff    <= 1'b0;
         first_ff        <= 1'b0;
      end else begin
         state_ff        <= state_in;
         clr_idx_ff      <= clr_idx_in;
         bucket_count_ff <= bucket_count_in;
         free_cnt_ff     <= free_cnt_in;
         hand_ff         <= hand_in;
         rsp_valid_ff    <= rsp_valid_in;
         first_ff        <= first_in;
      end
      op_ff         <= op_in;
      tag_ff        <= tag_in;
      slot_ff       <= slot_in;
      pp_ff         <= pp_in;
      wr_ff         <= wr_in;
      eb_ff         <= eb_in;
      home_ff       <= home_in;
      cur_ff        <= cur_in;
      prev_ff       <= prev_in;
      prev_ent_ff   <= prev_ent_in;
      cur_ent_ff    <= cur_ent_in;
      home_ent_ff   <= home_ent_in;
      row_ff        <= row_in;
      h_ff          <= h_in;
      cnt_ff        <= cnt_in;
      status_ff     <= status_in;
      pout_ff       <= pout_in;
      vout_ff       <= vout_in;
      dout_ff       <= dout_in;
      rsp_status_ff <= rsp_status_in;
      rsp_pout_ff   <= rsp_pout_in;
      rsp_vout_ff   <= rsp_vout_in;
      rsp_dout_ff   <= rsp_dout_in;
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_status            = rsp_status_ff;
   assign rsp_physical_page_out = rsp_pout_ff;
   assign rsp_victim_page       = rsp_vout_ff;
   assign rsp_victim_dirty      = rsp_dout_ff;
endmodule
